/* src/cesd_pkg.sv */
`default_nettype none

package cesd_pkg;

	// decoder state codes
	localparam logic [2:0] ST_PLAIN = 3'd0;
	localparam logic [2:0] ST_ESC   = 3'd1;
	localparam logic [2:0] ST_OCT1  = 3'd2;
	localparam logic [2:0] ST_OCT2  = 3'd3;
	localparam logic [2:0] ST_HEX0  = 3'd4;
	localparam logic [2:0] ST_HEXN  = 3'd5;

	// result kinds
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// source characters
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_V   = 8'h76;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_7  = 8'h37;
	localparam logic [7:0] CH_DIG_9  = 8'h39;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;

	// control codes produced by simple escapes
	localparam logic [7:0] CC_BEL = 8'h07;
	localparam logic [7:0] CC_BS  = 8'h08;
	localparam logic [7:0] CC_TAB = 8'h09;
	localparam logic [7:0] CC_LF  = 8'h0A;
	localparam logic [7:0] CC_VT  = 8'h0B;
	localparam logic [7:0] CC_FF  = 8'h0C;
	localparam logic [7:0] CC_CR  = 8'h0D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_end;
	} src_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  out_byte;
		logic [15:0] out_index;
		logic [31:0] total_length;
		logic [31:0] error_count;
		logic [15:0] terminator_index;
		logic        last;
	} dst_item_t;

	// up to two results written per decoded beat, first one first
	typedef struct packed {
		logic      en0;
		logic      en1;
		dst_item_t item0;
		dst_item_t item1;
	} res_wr_t;

	function automatic logic is_oct(input logic [7:0] b);
		return (b >= CH_DIG_0) && (b <= CH_DIG_7);
	endfunction

	function automatic logic [2:0] oct_val(input logic [7:0] b);
		return b[2:0];
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [7:0] d;
		d = 8'd0;
		if (b >= CH_DIG_0 && b <= CH_DIG_9) begin
			d = b - CH_DIG_0;
			return {1'b1, d[3:0]};
		end
		if (b >= CH_LC_A && b <= CH_LC_F) begin
			d = b - CH_LC_A + 8'd10;
			return {1'b1, d[3:0]};
		end
		if (b >= CH_UC_A && b <= CH_UC_F) begin
			d = b - CH_UC_A + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	// {known, byte}; an unknown escape passes the byte through
	function automatic logic [8:0] simple_escape(input logic [7:0] b);
		logic [8:0] r;
		unique case (b)
			CH_SQUOTE: r = {1'b1, CH_SQUOTE};
			CH_DQUOTE: r = {1'b1, CH_DQUOTE};
			CH_QMARK:  r = {1'b1, CH_QMARK};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_LC_A:   r = {1'b1, CC_BEL};
			CH_LC_B:   r = {1'b1, CC_BS};
			CH_LC_F:   r = {1'b1, CC_FF};
			CH_LC_N:   r = {1'b1, CC_LF};
			CH_LC_R:   r = {1'b1, CC_CR};
			CH_LC_T:   r = {1'b1, CC_TAB};
			CH_LC_V:   r = {1'b1, CC_VT};
			default:   r = {1'b0, b};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/c_escape_sequence_decoder_top.sv */
// a source beat is captured in the input register, then its results are written into the result queue
// throughput: one source beat per cycle while the queue has room; a two-result beat takes
//   two slots; the four-entry queue stalls the source when fewer than two slots are free
// reset: arst_n clears decoder state and counters, empties the queue, capacity to 65535
`default_nettype none

module c_escape_sequence_decoder_top #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [15:0]         cfg_wdata,
	input  wire logic                src_valid,
	output logic                     src_stall,
	input  wire cesd_pkg::src_item_t src_item,
	output logic                     dst_valid,
	input  wire logic                dst_stall,
	output cesd_pkg::dst_item_t      dst_item
);

	import cesd_pkg::*;

	logic [15:0] cap_q;
	logic        room;
	res_wr_t     wr;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 16'hFFFF;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	cesd_decode #(.COUNT_BITS(COUNT_BITS)) u_decode (
		.clk(clk), .arst_n(arst_n), .cap(cap_q),
		.src_valid(src_valid), .src_item(src_item), .src_stall(src_stall),
		.room(room), .wr(wr)
	);

	cesd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(wr), .room(room),
		.dst_valid(dst_valid), .dst_stall(dst_stall), .dst_item(dst_item)
	);

`ifndef NO_ASSERTIONS
	// a stored byte always sits below the terminator slot
	a_index_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.result_kind == KIND_BYTE
		|-> ({1'b0, dst_item.out_index} + 17'd1) < {1'b0, cap_q})
		else $error("byte index beyond capacity");

	// the summary is always the final beat of its item
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.result_kind == KIND_SUMMARY |-> dst_item.last)
		else $error("summary without last");

	// a byte that is not last must be followed by a further result
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_stall && !dst_item.last |=> dst_valid)
		else $error("first of two results without its follower");
`endif

endmodule

`default_nettype wire

/* src/cesd_emit.sv */
`default_nettype none

module cesd_emit #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                  en,
	input  wire logic [15:0]           cap,
	input  wire logic [COUNT_BITS-1:0] needed,
	input  wire logic [15:0]           stored,
	input  wire logic                  sync,
	output logic                       store,
	output logic [COUNT_BITS-1:0]      needed_nx,
	output logic [15:0]                stored_nx,
	output logic                       sync_nx
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [16:0] stored_inc;

	// a byte is kept only while nothing was dropped and there is room left
	assign stored_inc = {1'b0, stored} + 17'd1;
	assign store      = en && sync && (stored_inc < {1'b0, cap});

	always_comb begin
		needed_nx = needed;
		stored_nx = stored;
		sync_nx   = sync;
		if (en) begin
			if (needed != CNT_MAX)
				needed_nx = needed + 1'b1;
			if (store) begin
				stored_nx = stored_inc[15:0];
				// still in step unless the needed count has just saturated
				sync_nx   = 64'(stored_inc[15:0]) != 64'(CNT_MAX);
			end else begin
				sync_nx = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* src/cesd_decode.sv */
`default_nettype none

module cesd_decode #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [15:0]       cap,
	input  wire logic              src_valid,
	input  wire cesd_pkg::src_item_t src_item,
	output logic                   src_stall,
	input  wire logic              room,
	output cesd_pkg::res_wr_t      wr
);

	import cesd_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic                  valid_s1;
	src_item_t             item_s1;
	logic                  advance;

	logic [2:0]            st_q, st_nx;
	logic [7:0]            pend_q, pend_nx;
	logic [COUNT_BITS-1:0] needed_q;
	logic [COUNT_BITS-1:0] failure_q, failure_nx;
	logic [15:0]           stored_q;
	logic                  sync_q;

	logic                  a_en, b_en, err_inc;
	logic [7:0]            a_val, b;
	logic [8:0]            esc;
	logic [4:0]            hx;

	logic                  s0, s1st, sync0, sync1;
	logic [COUNT_BITS-1:0] need0, need1;
	logic [15:0]           stor0, stor1;
	logic [63:0]           need64, fail64;

	// input stage
	assign advance   = valid_s1 && room;
	assign src_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall)
			item_s1 <= src_item;
	end

	// escape state machine
	assign b   = item_s1.data_byte;
	assign esc = simple_escape(b);
	assign hx  = hex_val(b);

	always_comb begin
		st_nx   = st_q;
		pend_nx = pend_q;
		a_en    = 1'b0;
		a_val   = b;
		b_en    = 1'b0;
		err_inc = 1'b0;
		if (item_s1.is_end) begin
			if (st_q == ST_OCT1 || st_q == ST_OCT2 || st_q == ST_HEXN) begin
				a_en  = 1'b1;
				a_val = pend_q;
			end else if (st_q == ST_ESC || st_q == ST_HEX0) begin
				err_inc = 1'b1;
			end
			st_nx   = ST_PLAIN;
			pend_nx = 8'd0;
		end else begin
			unique case (st_q)
				ST_ESC: begin
					if (b == CH_X) begin
						st_nx = ST_HEX0;
					end else if (is_oct(b)) begin
						pend_nx = {5'd0, oct_val(b)};
						st_nx   = ST_OCT1;
					end else begin
						a_en    = 1'b1;
						a_val   = esc[7:0];
						err_inc = !esc[8];
						st_nx   = ST_PLAIN;
					end
				end
				ST_HEX0: begin
					if (hx[4]) begin
						pend_nx = {4'd0, hx[3:0]};
						st_nx   = ST_HEXN;
					end else begin
						err_inc = 1'b1;
						a_en    = 1'b1;
						st_nx   = ST_PLAIN;
					end
				end
				ST_HEXN, ST_OCT1, ST_OCT2: begin
					if (st_q == ST_HEXN && hx[4]) begin
						pend_nx = {pend_q[3:0], hx[3:0]};
					end else if (st_q == ST_OCT1 && is_oct(b)) begin
						pend_nx = {pend_q[4:0], oct_val(b)};
						st_nx   = ST_OCT2;
					end else if (st_q == ST_OCT2 && is_oct(b)) begin
						pend_nx = {pend_q[4:0], oct_val(b)};
						a_en    = 1'b1;
						a_val   = {pend_q[4:0], oct_val(b)};
						st_nx   = ST_PLAIN;
					end else begin
						// digit run ends: flush it, then take the byte as plain
						a_en  = 1'b1;
						a_val = pend_q;
						if (b == CH_BSLASH) begin
							st_nx = ST_ESC;
						end else begin
							b_en  = 1'b1;
							st_nx = ST_PLAIN;
						end
					end
				end
				default: begin
					if (b == CH_BSLASH) begin
						st_nx = ST_ESC;
					end else begin
						a_en  = 1'b1;
						st_nx = ST_PLAIN;
					end
				end
			endcase
		end
	end

	assign failure_nx = (err_inc && failure_q != CNT_MAX) ? failure_q + 1'b1 : failure_q;

	// two emits in sequence
	cesd_emit #(.COUNT_BITS(COUNT_BITS)) u_emit0 (
		.en(a_en), .cap(cap), .needed(needed_q), .stored(stored_q), .sync(sync_q),
		.store(s0), .needed_nx(need0), .stored_nx(stor0), .sync_nx(sync0)
	);

	cesd_emit #(.COUNT_BITS(COUNT_BITS)) u_emit1 (
		.en(b_en), .cap(cap), .needed(need0), .stored(stor0), .sync(sync0),
		.store(s1st), .needed_nx(need1), .stored_nx(stor1), .sync_nx(sync1)
	);

	// result beats
	assign need64 = 64'(need0);
	assign fail64 = 64'(failure_nx);

	always_comb begin
		wr.en0                         = advance && s0;
		wr.en1                         = advance && (s1st || item_s1.is_end);
		wr.item0                       = '0;
		wr.item0.result_kind           = KIND_BYTE;
		wr.item0.out_byte              = a_val;
		wr.item0.out_index             = stored_q;
		wr.item0.last                  = !(s1st || item_s1.is_end);
		wr.item1                       = '0;
		wr.item1.last                  = 1'b1;
		if (item_s1.is_end) begin
			wr.item1.result_kind      = KIND_SUMMARY;
			wr.item1.total_length     = (need64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
				: need64[31:0];
			wr.item1.error_count      = (fail64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
				: fail64[31:0];
			wr.item1.terminator_index = stor0;
		end else begin
			wr.item1.result_kind      = KIND_BYTE;
			wr.item1.out_byte         = b;
			wr.item1.out_index        = stor0;
		end
	end

	// decoder state, cleared by an end beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_PLAIN;
			pend_q    <= 8'd0;
			needed_q  <= '0;
			stored_q  <= 16'd0;
			failure_q <= '0;
			sync_q    <= 1'b1;
		end else if (advance) begin
			st_q   <= st_nx;
			pend_q <= pend_nx;
			if (item_s1.is_end) begin
				needed_q  <= '0;
				stored_q  <= 16'd0;
				failure_q <= '0;
				sync_q    <= 1'b1;
			end else begin
				needed_q  <= need1;
				stored_q  <= stor1;
				failure_q <= failure_nx;
				sync_q    <= sync1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/cesd_fifo.sv */
`default_nettype none

module cesd_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cesd_pkg::res_wr_t   wr,
	output logic                     room,
	output logic                     dst_valid,
	input  wire logic                dst_stall,
	output cesd_pkg::dst_item_t      dst_item
);

	import cesd_pkg::*;

	dst_item_t  mem_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] n_wr;

	assign dst_valid = count_q != 3'd0;
	assign dst_item  = mem_q[rd_ptr_q];
	assign pop       = dst_valid && !dst_stall;
	// space for a full two-result beat
	assign room      = count_q <= 3'd2;
	assign n_wr      = {1'b0, wr.en0} + {1'b0, wr.en1};

	always_ff @(posedge clk) begin
		if (wr.en0)
			mem_q[wr_ptr_q] <= wr.item0;
		if (wr.en1)
			mem_q[wr_ptr_q + {1'b0, wr.en0}] <= wr.item1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_wr;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {1'b0, n_wr} - {2'd0, pop};
		end
	end

endmodule

`default_nettype wire

/* tb/sv/c_escape_sequence_decoder_top_test.sv */
module c_escape_sequence_decoder_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cesd_pkg::*;

	localparam logic [31:0] COUNT_MAX = '1;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_PRINTED = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic src_valid = 1'b0;
	logic src_stall;
	src_item_t src_item = '0;
	logic dst_valid;
	logic dst_stall = 1'b0;
	dst_item_t dst_item;

	// decoder state mirror
	logic [15:0] cap_model = 16'hFFFF;
	logic [2:0] dec_state = ST_PLAIN;
	logic [7:0] pend_val = '0;
	logic [31:0] need_cnt = '0;
	logic [15:0] store_cnt = '0;
	logic [31:0] err_cnt = '0;

	// results of the beat being decoded, then the queue of decoded results in order
	dst_item_t beat_res[2];
	int beat_n;
	dst_item_t decoded_q[$];

	bit no_idle = 1'b0;
	int mismatches = 0;
	int beats_sent = 0;
	int strings_ended = 0;
	int results_seen = 0;
	int cap_writes = 0;

	logic [7:0] simple_esc_chars[11] = '{CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH,
		CH_LC_A, CH_LC_B, CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T, CH_LC_V};

	c_escape_sequence_decoder_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item(src_item),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item(dst_item)
	);

	always #5ns clk = ~clk;

	// ---------------------------------------------------------------- decode mirror

	function automatic bit octal_digit(input logic [7:0] b);
		return b >= CH_DIG_0 && b <= CH_DIG_7;
	endfunction

	// low nibble of '0'..'9' is the digit, low nibble of 'a'/'A' plus 9 is ten
	function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
		v = b[3:0];
		if (b >= CH_DIG_0 && b <= CH_DIG_9)
			return 1'b1;
		if ((b >= CH_LC_A && b <= CH_LC_F) || (b >= CH_UC_A && b <= CH_UC_F)) begin
			v = b[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void count_failure();
		if (err_cnt != COUNT_MAX)
			err_cnt++;
	endfunction

	// a byte lands in the buffer only while nothing was dropped and room is left
	function automatic void emit_byte(input logic [7:0] c);
		dst_item_t r;
		if (need_cnt == {16'd0, store_cnt} && need_cnt != COUNT_MAX &&
				{1'b0, store_cnt} + 17'd1 < {1'b0, cap_model}) begin
			r = '0;
			r.result_kind = KIND_BYTE;
			r.out_byte = c;
			r.out_index = store_cnt;
			beat_res[beat_n] = r;
			beat_n++;
			store_cnt++;
		end
		if (need_cnt != COUNT_MAX)
			need_cnt++;
	endfunction

	function automatic void plain_char(input logic [7:0] b);
		if (b == CH_BSLASH) begin
			dec_state = ST_ESC;
		end else begin
			dec_state = ST_PLAIN;
			emit_byte(b);
		end
	endfunction

	function automatic void decode_source_beat(input src_item_t it);
		logic [7:0] b;
		logic [7:0] esc;
		logic [3:0] nib;
		bit known;
		dst_item_t r;
		b = it.data_byte;
		beat_n = 0;
		if (it.is_end) begin
			// flush a pending number, or count a dangling escape
			if (dec_state == ST_OCT1 || dec_state == ST_OCT2 || dec_state == ST_HEXN)
				emit_byte(pend_val);
			else if (dec_state == ST_ESC || dec_state == ST_HEX0)
				count_failure();
			r = '0;
			r.result_kind = KIND_SUMMARY;
			r.total_length = need_cnt;
			r.error_count = err_cnt;
			r.terminator_index = store_cnt;
			beat_res[beat_n] = r;
			beat_n++;
			dec_state = ST_PLAIN;
			pend_val = '0;
			need_cnt = '0;
			store_cnt = '0;
			err_cnt = '0;
			strings_ended++;
		end else begin
			case (dec_state)
				ST_ESC: begin
					if (b == CH_X) begin
						dec_state = ST_HEX0;
					end else if (octal_digit(b)) begin
						pend_val = {5'd0, b[2:0]};
						dec_state = ST_OCT1;
					end else begin
						known = 1'b1;
						case (b)
							CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH: esc = b;
							CH_LC_A: esc = CC_BEL;
							CH_LC_B: esc = CC_BS;
							CH_LC_F: esc = CC_FF;
							CH_LC_N: esc = CC_LF;
							CH_LC_R: esc = CC_CR;
							CH_LC_T: esc = CC_TAB;
							CH_LC_V: esc = CC_VT;
							default: begin
								esc = b;
								known = 1'b0;
							end
						endcase
						if (!known)
							count_failure();
						emit_byte(esc);
						dec_state = ST_PLAIN;
					end
				end
				ST_HEX0: begin
					if (hex_nibble(b, nib)) begin
						pend_val = {4'd0, nib};
						dec_state = ST_HEXN;
					end else begin
						count_failure();
						emit_byte(b);
						dec_state = ST_PLAIN;
					end
				end
				ST_HEXN: begin
					if (hex_nibble(b, nib)) begin
						pend_val = {pend_val[3:0], nib};
					end else begin
						emit_byte(pend_val);
						plain_char(b);
					end
				end
				ST_OCT1: begin
					if (octal_digit(b)) begin
						pend_val = {pend_val[4:0], b[2:0]};
						dec_state = ST_OCT2;
					end else begin
						emit_byte(pend_val);
						plain_char(b);
					end
				end
				ST_OCT2: begin
					emit_byte(octal_digit(b) ? {pend_val[4:0], b[2:0]} : pend_val);
					if (octal_digit(b))
						dec_state = ST_PLAIN;
					else
						plain_char(b);
				end
				default: plain_char(b);
			endcase
		end
		if (beat_n > 0)
			beat_res[beat_n - 1].last = 1'b1;
		for (int i = 0; i < beat_n; i++)
			decoded_q.push_back(beat_res[i]);
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
				results_seen, name, got, want));
	endtask

	task automatic check_result(input dst_item_t got);
		dst_item_t want;
		results_seen++;
		if (decoded_q.size() == 0) begin
			report_mismatch($sformatf("result %0d with nothing pending: kind %0d byte %02h",
				results_seen, got.result_kind, got.out_byte));
			return;
		end
		want = decoded_q.pop_front();
		cmp_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
		cmp_field("out_byte", 32'(got.out_byte), 32'(want.out_byte));
		cmp_field("out_index", 32'(got.out_index), 32'(want.out_index));
		cmp_field("total_length", got.total_length, want.total_length);
		cmp_field("error_count", got.error_count, want.error_count);
		cmp_field("terminator_index", 32'(got.terminator_index),
			32'(want.terminator_index));
		cmp_field("last", 32'(got.last), 32'(want.last));
	endtask

	// output beat monitor
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall)
			check_result(dst_item);
	end

	// random back-pressure on the result side
	always @(posedge clk) begin
		dst_stall <= !no_idle && ($urandom_range(0, 99) < 31);
	end

	// ---------------------------------------------------------------- driving

	// one source beat, with a random gap in front of it
	task automatic send_beat(input logic [7:0] b, input logic e);
		src_item_t it;
		it.data_byte = b;
		it.is_end = e;
		if (!no_idle && $urandom_range(0, 99) < 31) begin
			src_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 31);
		end
		src_valid <= 1'b1;
		src_item <= it;
		do
			@(posedge clk);
		while (src_stall);
		decode_source_beat(it);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	task automatic end_string();
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// drop valid, wait out every pending result plus a beat that gives none
	task automatic settle();
		src_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_model = v;
		cap_writes++;
	endtask

	function automatic logic [7:0] rand_octal();
		return CH_DIG_0 + 8'($urandom_range(0, 7));
	endfunction

	task automatic send_random_string(input int max_tokens);
		int n;
		int v;
		n = $urandom_range(0, max_tokens);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1, 2: send_beat(8'($urandom_range(0, 255)), 1'b0);
				3: begin
					send_beat(CH_BSLASH, 1'b0);
					send_beat(simple_esc_chars[4'($urandom_range(0, 10))], 1'b0);
				end
				4: begin
					send_beat(CH_BSLASH, 1'b0);
					repeat ($urandom_range(1, 3)) send_beat(rand_octal(), 1'b0);
				end
				5: begin
					send_beat(CH_BSLASH, 1'b0);
					send_beat(CH_X, 1'b0);
					repeat ($urandom_range(1, 4)) begin
						v = $urandom_range(0, 15);
						if (v < 10)
							send_beat(CH_DIG_0 + 8'(v), 1'b0);
						else
							send_beat(($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(v - 10), 1'b0);
					end
				end
				// escape with any byte, mostly unknown ones
				6: begin
					send_beat(CH_BSLASH, 1'b0);
					send_beat(8'($urandom_range(0, 255)), 1'b0);
				end
				7: begin
					send_beat(CH_BSLASH, 1'b0);
					send_beat(CH_X, 1'b0);
					send_beat(8'($urandom_range(0, 255)), 1'b0);
				end
				// bare digit that may extend a number run
				8: send_beat(rand_octal(), 1'b0);
				default: send_beat(CH_BSLASH, 1'b0);
			endcase
		end
		end_string();
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_plain_bytes();
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'hFF, 1'b1);
		// empty string, end beat carrying a backslash that must be ignored
		send_beat(CH_BSLASH, 1'b1);
	endtask

	task automatic test_simple_and_bad_escapes();
		send_text("\\n\\\\\\q\\xg");
		end_string();
	endtask

	task automatic test_numeric_escapes();
		// full three-digit octal
		send_text("\\101");
		// short octal ended by a plain byte, then a dangling backslash
		send_text("\\7a\\");
		end_string();
		// overlong hex flushed by the end beat
		send_text("\\x1FfF");
		end_string();
		// dangling hex prefix
		send_text("\\x");
		end_string();
	endtask

	task automatic test_capacity_limits();
		settle();
		write_capacity(16'd0);
		send_text("ab");
		end_string();
		settle();
		write_capacity(16'd1);
		send_text("a");
		end_string();
		settle();
		write_capacity(16'd3);
		send_text("abcd");
		end_string();
		// buffer fills mid-string, a raised capacity must not reopen it
		settle();
		write_capacity(16'd2);
		send_text("ab");
		settle();
		write_capacity(16'hFFFF);
		send_text("c");
		end_string();
	endtask

	task automatic test_random_strings();
		int round;
		int target;
		round = 0;
		target = beats_sent + 1600;
		while (beats_sent < target) begin
			settle();
			case (round % 5)
				0: write_capacity(16'hFFFF);
				1: write_capacity(16'($urandom_range(0, 16)));
				2: write_capacity(16'd1);
				3: write_capacity(16'($urandom_range(0, 65535)));
				default: write_capacity(16'($urandom_range(2, 40)));
			endcase
			no_idle = (round >= 12 && round < 20);
			repeat (3) send_random_string(14);
			round++;
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_bytes();
		test_simple_and_bad_escapes();
		test_numeric_escapes();
		test_capacity_limits();
		test_random_strings();
		settle();
		repeat (20) @(posedge clk);
		$display("decoded %0d source beats in %0d strings, %0d results checked",
			beats_sent, strings_ended, results_seen);
		$display("buffer capacity rewritten %0d times, from 0 up to 65535", cap_writes);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
src/cesd_pkg.sv
src/cesd_emit.sv
src/cesd_decode.sv
src/cesd_fifo.sv
src/c_escape_sequence_decoder_top.sv
tb/sv/c_escape_sequence_decoder_top_test.sv
